// ----- hw/rtl/dsgf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Direct-sum gravity force package
// Shared types, field widths and arithmetic helpers for the force unit.
// ----------------------------------------------------------------------------
package dsgf_pkg;

    localparam int POS_W   = 32;
    localparam int MASS_W  = 32;
    localparam int SLOT_W  = 10;
    localparam int FORCE_W = 40;
    localparam int CNT_W   = 11;
    localparam int PADDR_W = 3;

    // Multiplier operand and product widths.
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Register index is paddr[2]; low address bits are ignored.
    localparam logic REG_SOFTENING = 1'b0;
    localparam logic REG_ACTIVE    = 1'b1;

    localparam logic [31:0] SOFTENING_RESET = 32'd65536;

    typedef struct packed {
        logic                     opcode;
        logic [SLOT_W-1:0]        slot;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_z;
        logic [MASS_W-1:0]        mass;
    } t_cmd;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic [MASS_W-1:0]       m;
    } t_part;

    typedef struct packed {
        logic empty;
        logic full;
    } t_front_status;

    function automatic logic [PROD_W-1:0] umul(input logic [MUL_W-1:0] a,
                                                input logic [MUL_W-1:0] b);
        umul = PROD_W'(a) * PROD_W'(b);
    endfunction

endpackage

// ----- hw/rtl/dsgf_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Force unit channel interfaces
// Request channel (particle writes and queries) and result channel.
// ----------------------------------------------------------------------------
interface dsgf_in_if;
    logic                               valid;
    logic                               ready;
    logic                               opcode;
    logic [dsgf_pkg::SLOT_W-1:0]        slot;
    logic signed [dsgf_pkg::POS_W-1:0]  pos_x;
    logic signed [dsgf_pkg::POS_W-1:0]  pos_y;
    logic signed [dsgf_pkg::POS_W-1:0]  pos_z;
    logic [dsgf_pkg::MASS_W-1:0]        mass;

    modport source (output valid, opcode, slot, pos_x, pos_y, pos_z, mass, input ready);
    modport sink   (input valid, opcode, slot, pos_x, pos_y, pos_z, mass, output ready);
endinterface

interface dsgf_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [dsgf_pkg::FORCE_W-1:0] force_x;
    logic signed [dsgf_pkg::FORCE_W-1:0] force_y;
    logic signed [dsgf_pkg::FORCE_W-1:0] force_z;
    logic                                saturated;

    modport source (output valid, force_x, force_y, force_z, saturated, input ready);
    modport sink   (input valid, force_x, force_y, force_z, saturated, output ready);
endinterface

// ----- hw/rtl/direct_sum_gravity_force_unit.sv -----
`timescale 1ns / 1ps
// A particle write is stored in the table as the idle engine takes it from the queue.
// A query walks the active particles in turn; a coincident particle skips the
// square root and dividers. The result then waits for a free output register.
// The engine takes one item at a time, held by the shared multiplier, the 33-step
// square root and the 40-step dividers that each particle passes through.
// Reset (synchronous, active low) clears control state; the table is not cleared.
// ----------------------------------------------------------------------------
// Direct-sum gravity force unit
// Stores particles and returns the Plummer-softened gravity sum at a target.
// ----------------------------------------------------------------------------
module direct_sum_gravity_force_unit #(
    parameter int MAX_PARTICLES = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    dsgf_in_if.sink                           i_in,
    dsgf_out_if.source                        o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dsgf_pkg::PADDR_W-1:0]      paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    // Configuration registers. The register index is paddr[2], so any
    // address within a register's word lands on that register.
    logic [31:0]                  r_softening;
    logic [dsgf_pkg::CNT_W-1:0]   r_active_count;
    logic                         cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_softening    <= dsgf_pkg::SOFTENING_RESET;
            r_active_count <= '0;
        end else if (cfg_wr) begin
            case (paddr[2])
                dsgf_pkg::REG_SOFTENING: r_softening    <= pwdata;
                dsgf_pkg::REG_ACTIVE:    r_active_count <= pwdata[dsgf_pkg::CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            dsgf_pkg::REG_SOFTENING: prdata = r_softening;
            dsgf_pkg::REG_ACTIVE:    prdata = 32'(r_active_count);
            default:                 prdata = '0;
        endcase
    end

    // Front end: packs each accepted item into a command and queues it.
    dsgf_pkg::t_cmd          in_cmd, q_cmd;
    logic                    q_valid, q_ready;
    dsgf_pkg::t_front_status front_st;

    assign in_cmd.opcode = i_in.opcode;
    assign in_cmd.slot   = i_in.slot;
    assign in_cmd.pos_x  = i_in.pos_x;
    assign in_cmd.pos_y  = i_in.pos_y;
    assign in_cmd.pos_z  = i_in.pos_z;
    assign in_cmd.mass   = i_in.mass;

    dsgf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .o_ready     (i_in.ready),
        .i_cmd       (in_cmd),
        .o_cmd_valid (q_valid),
        .i_cmd_ready (q_ready),
        .o_cmd       (q_cmd),
        .o_status    (front_st)
    );

    // Back end: table writes in order with queries, and the force walk.
    dsgf_back #(
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (q_valid),
        .o_cmd_ready    (q_ready),
        .i_cmd          (q_cmd),
        .i_softening    (r_softening),
        .i_active_count (r_active_count),
        .o_valid        (o_out.valid),
        .i_ready        (o_out.ready),
        .o_force_x      (o_out.force_x),
        .o_force_y      (o_out.force_y),
        .o_force_z      (o_out.force_z),
        .o_saturated    (o_out.saturated)
    );

    // A full queue always has an item on offer to the engine.
    a_full_offers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_st.full |-> q_valid)
        else $error("queue full without a command on offer");

    // The front end refuses items only when its queue is full.
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> front_st.full && !front_st.empty)
        else $error("input stalled with room in the queue");

    // A waiting result holds its value until it is taken.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.force_x)
        && $stable(o_out.saturated))
        else $error("result changed while stalled");

endmodule

// ----- hw/rtl/dsgf_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Force unit front end
// Accepts commands and queues them for the engine.
// ----------------------------------------------------------------------------
module dsgf_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  dsgf_pkg::t_cmd         i_cmd,
    output logic                   o_cmd_valid,
    input  logic                   i_cmd_ready,
    output dsgf_pkg::t_cmd         o_cmd,
    output dsgf_pkg::t_front_status o_status
);

    // Two-entry queue.
    dsgf_pkg::t_cmd r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           push, pop;

    assign o_ready     = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign push        = i_valid && o_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_status.empty = (r_cnt == 2'd0);
    assign o_status.full  = (r_cnt == 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

endmodule

// ----- hw/rtl/dsgf_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Force unit engine
// Holds the particle table and walks it for each query with one shared
// multiplier, a bit-serial square root and three bit-serial dividers.
// ----------------------------------------------------------------------------
module dsgf_back #(
    parameter int MAX_PARTICLES = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cmd_valid,
    output logic                            o_cmd_ready,
    input  dsgf_pkg::t_cmd                  i_cmd,
    input  logic [31:0]                     i_softening,
    input  logic [dsgf_pkg::CNT_W-1:0]      i_active_count,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [dsgf_pkg::FORCE_W-1:0] o_force_x,
    output logic signed [dsgf_pkg::FORCE_W-1:0] o_force_y,
    output logic signed [dsgf_pkg::FORCE_W-1:0] o_force_z,
    output logic                            o_saturated
);

    localparam int IW    = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int CW    = $clog2(MAX_PARTICLES + 1);
    localparam int DW    = 32;            // magnitude of a coordinate difference
    localparam int SW    = 66;            // sum of squares plus eps^2
    localparam int RW    = 33;            // floor square root of that sum
    localparam int WW    = 99;            // s * r
    localparam int REMW  = WW + 1;
    localparam int QW    = 40;
    localparam int TW    = QW + 2;        // signed capped term
    localparam int ACC_W = TW + CW;
    localparam int SQRW  = RW + 4;
    localparam int MASS_W_L = dsgf_pkg::MASS_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_EPS, ST_FETCH, ST_LOAD, ST_SQX, ST_SQY, ST_SQZ, ST_SQI,
        ST_SQRT, ST_W0, ST_W1, ST_MD, ST_DIVI, ST_DIV, ST_ACC, ST_DONE
    } t_state;

    t_state r_state;

    dsgf_pkg::t_part r_mem [MAX_PARTICLES];
    dsgf_pkg::t_part r_rd;

    logic signed [dsgf_pkg::POS_W-1:0] r_tx, r_ty, r_tz;
    logic [CW-1:0]    r_n, r_idx;
    logic [63:0]      r_eps2;
    logic [DW-1:0]    r_mag [3];
    logic [2:0]       r_neg;
    logic [MASS_W_L-1:0] r_mass;
    logic [SW-1:0]    r_s, r_sq_src;
    logic [RW-1:0]    r_root;
    logic [RW+1:0]    r_sqrem;
    logic [WW-1:0]    r_w;
    logic [REMW-1:0]  r_rem [3];
    logic [QW-1:0]    r_q [3];
    logic [2:0]       r_cap;
    logic [1:0]       r_ax;
    logic [5:0]       r_cnt;
    logic signed [ACC_W-1:0] r_acc [3];
    logic             r_sat;
    logic             r_out_valid;
    logic signed [dsgf_pkg::FORCE_W-1:0] r_fx, r_fy, r_fz;
    logic             r_fsat;

    // Shared multiplier operands.
    logic [dsgf_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic [dsgf_pkg::PROD_W-1:0] prod;

    // Difference of target and stored particle.
    logic signed [32:0] d [3];
    logic [31:0]        slot32;
    logic               wr_en;
    logic [SQRW-1:0]    sq_rem2, sq_trial;

    // Clamp values of the result range.
    localparam logic signed [ACC_W-1:0] OUT_MAX =
        ACC_W'((64'sd1 <<< (dsgf_pkg::FORCE_W - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] OUT_MIN =
        ACC_W'(-(64'sd1 <<< (dsgf_pkg::FORCE_W - 1)));

    function automatic logic over(input logic signed [ACC_W-1:0] v);
        over = (v > OUT_MAX) || (v < OUT_MIN);
    endfunction

    function automatic logic signed [dsgf_pkg::FORCE_W-1:0] clamp(
        input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] c;
        c = v;
        if (v > OUT_MAX) begin
            c = OUT_MAX;
        end else if (v < OUT_MIN) begin
            c = OUT_MIN;
        end
        clamp = c[dsgf_pkg::FORCE_W-1:0];
    endfunction

    assign o_cmd_ready = (r_state == ST_IDLE);
    assign slot32      = 32'(i_cmd.slot);
    assign wr_en       = i_cmd_valid && o_cmd_ready && (i_cmd.opcode == dsgf_pkg::OP_WRITE)
                         && (slot32 < 32'(MAX_PARTICLES));

    assign d[0] = 33'(r_tx) - 33'(r_rd.x);
    assign d[1] = 33'(r_ty) - 33'(r_rd.y);
    assign d[2] = 33'(r_tz) - 33'(r_rd.z);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_EPS: begin
                mul_a = 33'(i_softening);
                mul_b = 33'(i_softening);
            end
            ST_SQX, ST_SQY, ST_SQZ: begin
                mul_a = 33'(r_mag[r_ax]);
                mul_b = 33'(r_mag[r_ax]);
            end
            ST_W0: begin
                mul_a = r_s[32:0];
                mul_b = r_root;
            end
            ST_W1: begin
                mul_a = r_s[65:33];
                mul_b = r_root;
            end
            ST_MD: begin
                mul_a = 33'(r_mass);
                mul_b = 33'(r_mag[r_ax]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod     = dsgf_pkg::umul(mul_a, mul_b);
    assign sq_rem2  = {r_sqrem, r_sq_src[SW-1:SW-2]};
    assign sq_trial = {2'b00, r_root, 2'b01};

    // Particle table.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[slot32[IW-1:0]] <= '{x: i_cmd.pos_x, y: i_cmd.pos_y,
                                       z: i_cmd.pos_z, m: i_cmd.mass};
        end
        if (r_state == ST_FETCH) begin
            r_rd <= r_mem[r_idx[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid && i_cmd.opcode == dsgf_pkg::OP_QUERY) begin
                        r_tx  <= i_cmd.pos_x;
                        r_ty  <= i_cmd.pos_y;
                        r_tz  <= i_cmd.pos_z;
                        r_idx <= '0;
                        r_sat <= 1'b0;
                        for (int k = 0; k < 3; k++) begin
                            r_acc[k] <= '0;
                        end
                        if (32'(i_active_count) > 32'(MAX_PARTICLES)) begin
                            r_n <= CW'(MAX_PARTICLES);
                        end else begin
                            r_n <= CW'(i_active_count);
                        end
                        r_state <= ST_EPS;
                    end
                end
                ST_EPS: begin
                    r_eps2  <= prod[63:0];
                    r_state <= (r_n == '0) ? ST_DONE : ST_FETCH;
                end
                ST_FETCH: begin
                    r_state <= ST_LOAD;
                end
                ST_LOAD: begin
                    for (int k = 0; k < 3; k++) begin
                        r_neg[k] <= d[k][32];
                        r_mag[k] <= d[k][32] ? 32'(-d[k]) : d[k][31:0];
                    end
                    r_mass <= r_rd.m;
                    r_s    <= SW'(r_eps2);
                    r_ax   <= 2'd0;
                    if (d[0] == '0 && d[1] == '0 && d[2] == '0) begin
                        // A coincident particle contributes nothing.
                        r_state <= ST_ACC;
                        r_cap   <= '0;
                        for (int k = 0; k < 3; k++) begin
                            r_q[k] <= '0;
                        end
                    end else begin
                        r_state <= ST_SQX;
                    end
                end
                ST_SQX, ST_SQY: begin
                    r_s     <= r_s + prod;
                    r_ax    <= r_ax + 2'd1;
                    r_state <= (r_state == ST_SQX) ? ST_SQY : ST_SQZ;
                end
                ST_SQZ: begin
                    r_s     <= r_s + prod;
                    r_state <= ST_SQI;
                end
                ST_SQI: begin
                    r_sq_src <= r_s;
                    r_root   <= '0;
                    r_sqrem  <= '0;
                    r_cnt    <= '0;
                    r_state  <= ST_SQRT;
                end
                ST_SQRT: begin
                    r_sq_src <= r_sq_src << 2;
                    if (sq_rem2 >= sq_trial) begin
                        r_sqrem <= (RW + 2)'(sq_rem2 - sq_trial);
                        r_root  <= {r_root[RW-2:0], 1'b1};
                    end else begin
                        r_sqrem <= (RW + 2)'(sq_rem2);
                        r_root  <= {r_root[RW-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(RW - 1)) begin
                        r_state <= ST_W0;
                    end
                end
                ST_W0: begin
                    r_w     <= WW'(prod);
                    r_state <= ST_W1;
                end
                ST_W1: begin
                    r_w     <= r_w + (WW'(prod) << 33);
                    r_ax    <= 2'd0;
                    r_state <= ST_MD;
                end
                ST_MD: begin
                    r_rem[r_ax] <= REMW'(prod);
                    r_ax        <= r_ax + 2'd1;
                    if (r_ax == 2'd2) begin
                        r_state <= ST_DIVI;
                    end
                end
                ST_DIVI: begin
                    // Quotient reaches 2^40 exactly when m*|d| >= w.
                    for (int k = 0; k < 3; k++) begin
                        r_cap[k] <= (r_w == '0) || (r_rem[k] >= REMW'(r_w));
                        r_q[k]   <= '0;
                    end
                    r_cnt   <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    for (int k = 0; k < 3; k++) begin
                        if ({r_rem[k][REMW-2:0], 1'b0} >= REMW'(r_w)) begin
                            r_rem[k] <= {r_rem[k][REMW-2:0], 1'b0} - REMW'(r_w);
                            r_q[k]   <= {r_q[k][QW-2:0], 1'b1};
                        end else begin
                            r_rem[k] <= {r_rem[k][REMW-2:0], 1'b0};
                            r_q[k]   <= {r_q[k][QW-2:0], 1'b0};
                        end
                    end
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(QW - 1)) begin
                        r_state <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    for (int k = 0; k < 3; k++) begin
                        if (r_cap[k]) begin
                            r_acc[k] <= r_neg[k] ? r_acc[k] - (ACC_W'(1) << QW)
                                                 : r_acc[k] + (ACC_W'(1) << QW);
                        end else begin
                            r_acc[k] <= r_neg[k] ? r_acc[k] - ACC_W'(r_q[k])
                                                 : r_acc[k] + ACC_W'(r_q[k]);
                        end
                    end
                    r_sat <= r_sat | (|r_cap);
                    r_cap <= '0;
                    if (r_idx == r_n - CW'(1)) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= ST_FETCH;
                    end
                end
                ST_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_fx   <= clamp(r_acc[0]);
                        r_fy   <= clamp(r_acc[1]);
                        r_fz   <= clamp(r_acc[2]);
                        r_fsat <= r_sat || over(r_acc[0]) || over(r_acc[1]) || over(r_acc[2]);
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid     = r_out_valid;
    assign o_force_x   = r_fx;
    assign o_force_y   = r_fy;
    assign o_force_z   = r_fz;
    assign o_saturated = r_fsat;

endmodule

// ----- bench/tb_direct_sum_gravity_force_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Direct-sum gravity force unit testbench
// Loads the particle table, sets softening and active count over the APB port,
// issues force queries under random backpressure and compares each returned
// force with a bit-exact fixed-point prediction kept in the bench.
// ----------------------------------------------------------------------------
module tb_direct_sum_gravity_force_unit;

    localparam int TABLE_DEPTH = 1024;
    localparam int FILL_DEPTH  = 48;
    localparam logic [dsgf_pkg::PADDR_W-1:0] ADDR_SOFTENING = 3'd0;
    localparam logic [dsgf_pkg::PADDR_W-1:0] ADDR_ACTIVE    = 3'd4;
    localparam longint FORCE_MAX = (64'sd1 <<< 39) - 1;
    localparam longint FORCE_MIN = -(64'sd1 <<< 39);
    localparam logic [127:0] TERM_CAP = 128'd1 << 40;
    localparam int IDLE_LIMIT = 300000;

    typedef struct packed {
        logic signed [dsgf_pkg::FORCE_W-1:0] fx;
        logic signed [dsgf_pkg::FORCE_W-1:0] fy;
        logic signed [dsgf_pkg::FORCE_W-1:0] fz;
        logic                                sat;
    } t_force;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [dsgf_pkg::PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    dsgf_in_if  req_ch ();
    dsgf_out_if force_ch ();

    direct_sum_gravity_force_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (force_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the particle table and the two registers.
    logic signed [31:0] part_x [TABLE_DEPTH];
    logic signed [31:0] part_y [TABLE_DEPTH];
    logic signed [31:0] part_z [TABLE_DEPTH];
    logic [31:0]        part_m [TABLE_DEPTH];
    logic [31:0]        softening_q;
    logic [dsgf_pkg::CNT_W-1:0] active_q;

    dsgf_pkg::t_cmd pending_cmds [$];
    t_force         expected_forces [$];
    int             errors = 0;

    // Sender burst/gap state and receiver stall state.
    int burst_left = 0;
    int gap_left   = 0;
    int stall_req  = 0;
    int stall_done = 0;
    int stall_left = 0;
    int rx_mode    = 0;
    int rx_mode_left = 0;
    int idle_cycles = 0;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Integer square root of a wide value, bit by bit.
    function automatic logic [127:0] isqrt_wide(logic [127:0] v);
        logic [127:0] res = '0;
        logic [127:0] b = 128'd1 << 126;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Softened gravity sum at the target over the active part of the table.
    function automatic t_force predict_force(logic signed [31:0] tx, logic signed [31:0] ty,
                                             logic signed [31:0] tz);
        longint sum [3];
        longint d [3];
        longint mg;
        logic [127:0] s, w, num, q, eps2;
        logic [63:0] tval;
        bit sat = 0;
        int n;
        t_force f;
        sum[0] = 0; sum[1] = 0; sum[2] = 0;
        eps2 = 128'(softening_q) * 128'(softening_q);
        n = (active_q > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_q);
        for (int i = 0; i < n; i++) begin
            d[0] = longint'(tx) - longint'(part_x[i]);
            d[1] = longint'(ty) - longint'(part_y[i]);
            d[2] = longint'(tz) - longint'(part_z[i]);
            // A particle sitting exactly on the target contributes nothing.
            if (d[0] == 0 && d[1] == 0 && d[2] == 0) continue;
            s = eps2;
            for (int k = 0; k < 3; k++) begin
                mg = (d[k] < 0) ? -d[k] : d[k];
                s = s + 128'(mg) * 128'(mg);
            end
            w = s * isqrt_wide(s);
            for (int k = 0; k < 3; k++) begin
                if (d[k] == 0 || part_m[i] == 0) continue;
                mg = (d[k] < 0) ? -d[k] : d[k];
                num = (128'(part_m[i]) * 128'(mg)) << 40;
                if (w == 0) begin
                    q = TERM_CAP;
                end else begin
                    q = num / w;
                end
                if (q >= TERM_CAP) begin
                    q = TERM_CAP;
                    sat = 1;
                end
                tval = q[63:0];
                sum[k] = (d[k] < 0) ? sum[k] - longint'(tval) : sum[k] + longint'(tval);
            end
        end
        for (int k = 0; k < 3; k++) begin
            if (sum[k] > FORCE_MAX) begin
                sum[k] = FORCE_MAX;
                sat = 1;
            end
            if (sum[k] < FORCE_MIN) begin
                sum[k] = FORCE_MIN;
                sat = 1;
            end
        end
        f.fx = sum[0][dsgf_pkg::FORCE_W-1:0];
        f.fy = sum[1][dsgf_pkg::FORCE_W-1:0];
        f.fz = sum[2][dsgf_pkg::FORCE_W-1:0];
        f.sat = sat;
        return f;
    endfunction

    // Driver: presents the oldest pending item unless the sender is in a gap.
    always @(negedge i_clk) begin
        if (!i_rst_n || gap_left > 0 || pending_cmds.size() == 0) begin
            req_ch.valid <= 1'b0;
            if (gap_left > 0 && i_rst_n) gap_left <= gap_left - 1;
        end else begin
            req_ch.valid  <= 1'b1;
            req_ch.opcode <= pending_cmds[0].opcode;
            req_ch.slot   <= pending_cmds[0].slot;
            req_ch.pos_x  <= pending_cmds[0].pos_x;
            req_ch.pos_y  <= pending_cmds[0].pos_y;
            req_ch.pos_z  <= pending_cmds[0].pos_z;
            req_ch.mass   <= pending_cmds[0].mass;
        end
    end

    // Receiver: a long hold-off on request, otherwise a changing ready pattern.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            force_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stall_done < stall_req) begin
            force_ch.ready <= 1'b0;
            stall_left <= 600;
            stall_done <= stall_done + 1;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode <= $urandom_range(0, 3);
                rx_mode_left <= $urandom_range(10, 80);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                0: force_ch.ready <= 1'b1;
                1: force_ch.ready <= ($urandom_range(0, 1) == 0);
                2: force_ch.ready <= ($urandom_range(0, 3) == 0);
                default: force_ch.ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Input acceptance: update the shadow table or predict the query's force.
    always @(posedge i_clk) begin
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            if (req_ch.opcode == dsgf_pkg::OP_WRITE) begin
                part_x[req_ch.slot] = req_ch.pos_x;
                part_y[req_ch.slot] = req_ch.pos_y;
                part_z[req_ch.slot] = req_ch.pos_z;
                part_m[req_ch.slot] = req_ch.mass;
            end else begin
                expected_forces = {expected_forces,
                                   predict_force(req_ch.pos_x, req_ch.pos_y, req_ch.pos_z)};
            end
            void'(pending_cmds.pop_front());
            if (burst_left <= 1) begin
                // Now and then a long burst with no gap at all.
                if ($urandom_range(0, 3) == 0) begin
                    burst_left = $urandom_range(20, 60);
                    gap_left = 0;
                end else begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = $urandom_range(1, 9);
                end
            end else begin
                burst_left = burst_left - 1;
            end
        end
    end

    // Result monitor: compare each accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        t_force exp_f;
        if (i_rst_n && force_ch.valid && force_ch.ready) begin
            if (expected_forces.size() == 0) begin
                $display("%0t: unexpected result x=%h y=%h z=%h sat=%b", $time,
                         force_ch.force_x, force_ch.force_y, force_ch.force_z,
                         force_ch.saturated);
                errors++;
            end else begin
                exp_f = expected_forces.pop_front();
                if (force_ch.force_x !== exp_f.fx) begin
                    $display("%0t: force_x expected %h actual %h", $time, exp_f.fx,
                             force_ch.force_x);
                    errors++;
                end
                if (force_ch.force_y !== exp_f.fy) begin
                    $display("%0t: force_y expected %h actual %h", $time, exp_f.fy,
                             force_ch.force_y);
                    errors++;
                end
                if (force_ch.force_z !== exp_f.fz) begin
                    $display("%0t: force_z expected %h actual %h", $time, exp_f.fz,
                             force_ch.force_z);
                    errors++;
                end
                if (force_ch.saturated !== exp_f.sat) begin
                    $display("%0t: saturated expected %b actual %b", $time, exp_f.sat,
                             force_ch.saturated);
                    errors++;
                end
            end
        end
    end

    // Watchdog: any handshake on either channel or the register port counts
    // as progress; a long silence means the block is hung.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (force_ch.valid && force_ch.ready) ||
            (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_direct_sum_gravity_force_unit NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic reg_write(logic [dsgf_pkg::PADDR_W-1:0] addr, logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_SOFTENING) softening_q = val;
        else active_q = val[dsgf_pkg::CNT_W-1:0];
    endtask

    // Registers change only with the block drained; writes leave no result,
    // so an extra wait covers a write still being stored.
    task automatic wait_drained();
        while (pending_cmds.size() != 0 || expected_forces.size() != 0 || req_ch.valid)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic push_particle(int slot, logic signed [31:0] x, logic signed [31:0] y,
                                 logic signed [31:0] z, logic [31:0] m);
        dsgf_pkg::t_cmd c;
        c.opcode = dsgf_pkg::OP_WRITE;
        c.slot = slot[dsgf_pkg::SLOT_W-1:0];
        c.pos_x = x;
        c.pos_y = y;
        c.pos_z = z;
        c.mass = m;
        pending_cmds = {pending_cmds, c};
    endtask

    // The slot and mass fields of a query carry random junk.
    task automatic push_query(logic signed [31:0] x, logic signed [31:0] y,
                              logic signed [31:0] z);
        dsgf_pkg::t_cmd c;
        c.opcode = dsgf_pkg::OP_QUERY;
        c.slot = dsgf_pkg::SLOT_W'($urandom);
        c.pos_x = x;
        c.pos_y = y;
        c.pos_z = z;
        c.mass = $urandom;
        pending_cmds = {pending_cmds, c};
    endtask

    // Half full-range coordinates, half clustered near the origin.
    function automatic logic signed [31:0] rand_pos();
        if ($urandom_range(0, 1) == 0) return $urandom;
        return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
    endfunction

    function automatic logic [31:0] rand_mass();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($urandom_range(0, 1 << 16));
            default: return 32'($urandom_range(0, 1 << 22));
        endcase
    endfunction

    initial begin
        int sel, n_items, cnt;
        logic [31:0] soft_val;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_ch.valid = 1'b0;
        req_ch.opcode = dsgf_pkg::OP_WRITE;
        req_ch.slot = '0;
        req_ch.pos_x = '0;
        req_ch.pos_y = '0;
        req_ch.pos_z = '0;
        req_ch.mass = '0;
        force_ch.ready = 1'b0;
        softening_q = dsgf_pkg::SOFTENING_RESET;
        active_q = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            part_x[i] = '0;
            part_y[i] = '0;
            part_z[i] = '0;
            part_m[i] = '0;
        end
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // With the reset count of zero a query sums nothing.
        push_query(32'sh7fffffff, 32'sh80000000, 32'sh0);

        // Fill the low part of the table; every active count used below
        // stays inside the written entries.
        for (int i = 0; i < FILL_DEPTH; i++)
            push_particle(i, rand_pos(), rand_pos(), rand_pos(), rand_mass());
        wait_drained();

        // Whole filled region, one query on top of particle five.
        reg_write(ADDR_ACTIVE, 32'(FILL_DEPTH));
        push_query(rand_pos(), rand_pos(), rand_pos());
        wait_drained();
        push_query(part_x[5], part_y[5], part_z[5]);
        wait_drained();

        // Largest softening over the filled region.
        reg_write(ADDR_SOFTENING, 32'hffffffff);
        push_query(rand_pos(), rand_pos(), rand_pos());
        wait_drained();

        // Extreme offsets: heavy particle at the most negative corner, a
        // massless one at the most positive corner where the target sits.
        reg_write(ADDR_ACTIVE, 32'd2);
        reg_write(ADDR_SOFTENING, 32'd0);
        push_particle(0, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'hffffffff);
        push_particle(1, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'h0);
        push_query(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        push_query(32'sh80000000, 32'sh80000000, 32'sh80000001);
        // Zero softening one step away from a heavy particle clamps the sum.
        push_particle(1, 32'sh0, 32'sh0, 32'sh0, 32'hffffffff);
        push_query(32'sh1, 32'sh0, 32'sh0);
        push_query(32'sh0, 32'shffffffff, 32'sh1);
        push_query(32'sh0, 32'sh0, 32'sh0);
        wait_drained();
        reg_write(ADDR_SOFTENING, 32'hffffffff);
        push_query(32'sh1, 32'sh0, 32'sh0);
        push_query(32'sh7fffffff, 32'sh0, 32'sh80000000);
        push_particle(1023, 32'sh12345, -32'sh6789a, 32'sh0, 32'h10000);
        push_particle(682, 32'sh55555555, 32'shaaaaaaaa, 32'sh55555555, 32'haaaaaaaa);
        wait_drained();
        reg_write(ADDR_ACTIVE, 32'd1);
        reg_write(ADDR_SOFTENING, dsgf_pkg::SOFTENING_RESET);
        push_query(32'sh10000, 32'sh0, 32'sh0);
        wait_drained();

        // Random phases: new registers, then a mix of table updates and
        // queries over a small active region.
        for (int ph = 0; ph < 8; ph++) begin
            sel = $urandom_range(0, 4);
            case (sel)
                0: soft_val = 32'd0;
                1: soft_val = 32'hffffffff;
                2: soft_val = dsgf_pkg::SOFTENING_RESET;
                default: soft_val = $urandom_range(0, 1 << 20);
            endcase
            cnt = (ph == 0) ? 0 : $urandom_range(1, 16);
            reg_write(ADDR_SOFTENING, soft_val);
            reg_write(ADDR_ACTIVE, 32'(cnt));
            // One phase makes the receiver hold off while queries pile up.
            if (ph == 3) stall_req = stall_req + 1;
            n_items = 64;
            for (int k = 0; k < n_items; k++) begin
                sel = $urandom_range(0, 9);
                if (sel < 5) begin
                    push_particle($urandom_range(0, (cnt > 0) ? cnt + 2 : 20), rand_pos(),
                                  rand_pos(), rand_pos(), rand_mass());
                end else if (sel == 5 && cnt > 0) begin
                    // Target taken from the shadow table when queued; a
                    // write still pending may move the particle away from it.
                    push_query(part_x[0], part_y[0], part_z[0]);
                end else begin
                    push_query(rand_pos(), rand_pos(), rand_pos());
                end
            end
            wait_drained();
        end

        if (errors == 0) begin
            $display("tb_direct_sum_gravity_force_unit OK");
        end else begin
            $display("tb_direct_sum_gravity_force_unit NOT OK");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/dsgf_pkg.sv
hw/rtl/dsgf_if.sv
hw/rtl/dsgf_front.sv
hw/rtl/dsgf_back.sv
hw/rtl/direct_sum_gravity_force_unit.sv
bench/tb_direct_sum_gravity_force_unit.sv
